@@ src/ska_pkg.sv @@
// Shared types, constants and saturating arithmetic for the sorted key accumulate table.
`default_nettype none
package ska_pkg;

	localparam int CAPACITY = 1024;
	localparam int LEVELS   = 10;
	localparam int IDX_W    = 10;
	localparam int POS_W    = 11;
	localparam int LVL_W    = 4;
	localparam int DEPT_W   = 16;
	localparam int PLU_W    = 47;
	localparam int KEY_W    = DEPT_W + PLU_W;
	localparam int QTY_W    = 32;
	localparam int AMT_W    = 40;
	localparam int IN_W     = 152;
	localparam int OUT_W    = 160;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_OOR  = 2'd2;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [LEVELS-1:0][QTY_W-1:0] qty_row_t;
	typedef logic [LEVELS-1:0][AMT_W-1:0] amt_row_t;

	// Broadcast from the control to every cell.
	typedef struct packed {
		logic             shift;
		logic             load;
		logic             wr;
		logic [LVL_W-1:0] level;
		key_t             key;
		logic [QTY_W-1:0] qty;
		logic [AMT_W-1:0] amt;
	} cell_ctl_t;

	// What one cell reports back to the control.
	typedef struct packed {
		logic             lt;
		logic             eq;
		logic [QTY_W-1:0] qty;
		logic [AMT_W-1:0] amt;
	} cell_stat_t;

	function automatic logic [QTY_W-1:0] sat_qty(input logic [QTY_W-1:0] a,
		input logic [QTY_W-1:0] b);
		logic [QTY_W:0] s;
		s = {a[QTY_W-1], a} + {b[QTY_W-1], b};
		if (s[QTY_W] != s[QTY_W-1])
			return s[QTY_W] ? {1'b1, {(QTY_W-1){1'b0}}} : {1'b0, {(QTY_W-1){1'b1}}};
		return s[QTY_W-1:0];
	endfunction

	function automatic logic [AMT_W-1:0] sat_amt(input logic [AMT_W-1:0] a,
		input logic [AMT_W-1:0] b);
		logic [AMT_W:0] s;
		s = {a[AMT_W-1], a} + {b[AMT_W-1], b};
		if (s[AMT_W] != s[AMT_W-1])
			return s[AMT_W] ? {1'b1, {(AMT_W-1){1'b0}}} : {1'b0, {(AMT_W-1){1'b1}}};
		return s[AMT_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ src/ska_cell.sv @@
// One table entry of the sorted chain: key, level totals, compare and shift logic.
`default_nettype none
module ska_cell (
	input  wire                   clk,
	input  ska_pkg::cell_ctl_t    ctl,
	input  wire                   valid,
	input  wire                   sel,
	input  wire                   after,
	input  ska_pkg::key_t         left_key,
	input  ska_pkg::qty_row_t     left_qty,
	input  ska_pkg::amt_row_t     left_amt,
	output ska_pkg::key_t         key,
	output ska_pkg::qty_row_t     qty,
	output ska_pkg::amt_row_t     amt,
	output ska_pkg::cell_stat_t   stat
);
	import ska_pkg::*;

	key_t     key_q;
	qty_row_t qty_q;
	amt_row_t amt_q;
	logic     lvl_ok;

	assign lvl_ok = ctl.level < LVL_W'(LEVELS);

	always_ff @(posedge clk) begin
		if (ctl.shift && after) begin
			key_q <= left_key;
			qty_q <= left_qty;
			amt_q <= left_amt;
		end else if (ctl.load && sel) begin
			key_q <= ctl.key;
			for (int j = 0; j < LEVELS; j++) begin
				qty_q[j] <= (lvl_ok && ctl.level == LVL_W'(j)) ? ctl.qty : '0;
				amt_q[j] <= (lvl_ok && ctl.level == LVL_W'(j)) ? ctl.amt : '0;
			end
		end else if (ctl.wr && sel && lvl_ok) begin
			qty_q[ctl.level] <= ctl.qty;
			amt_q[ctl.level] <= ctl.amt;
		end
	end

	assign key = key_q;
	assign qty = qty_q;
	assign amt = amt_q;

	always_comb begin
		stat.lt  = valid && (key_q < ctl.key);
		stat.eq  = valid && (key_q == ctl.key);
		stat.qty = (sel && lvl_ok) ? qty_q[ctl.level] : '0;
		stat.amt = (sel && lvl_ok) ? amt_q[ctl.level] : '0;
	end

endmodule
`default_nettype wire

@@ src/sorted_key_accumulate_table.sv @@
// An accepted word passes through the compare, select, gather and update steps to its result word.
// The sequencer holds each word through all steps and takes no new word until the last one is through.
// The update step waits while an earlier result word has not been taken.
// Reset clears the entry count and the sequencer; entry contents stay undefined until written.
// No clearing pass is needed after reset.
`default_nettype none
module sorted_key_accumulate_table (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      s_tvalid,
	output logic                     s_tready,
	// dept_no, plu_no, price_level, qty, amount, entry_index, zero fill (lowest first)
	input  wire [ska_pkg::IN_W-1:0]  s_tdata,
	// cmd
	input  wire                      s_tuser,
	output logic                     m_tvalid,
	input  wire                      m_tready,
	// found, position, dept_out, plu_out, qty_total, amount_total, status, entry_count
	output logic [ska_pkg::OUT_W-1:0] m_tdata
);
	import ska_pkg::*;

	// The word sits in a holding register while the whole chain compares against its key
	// at once. The boundary between the cells whose key is lower and the rest marks the
	// position. A hit adds through the shared saturating quantity and amount adders; a miss
	// shifts every cell past the position one place along the chain and loads the new key there.
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CMP  = 5'b00010,
		S_SEL  = 5'b00100,
		S_GAT  = 5'b01000,
		S_UPD  = 5'b10000
	} state_t;

	state_t state_q;

	logic               cmd_q;
	logic [DEPT_W-1:0]  dept_q;
	logic [PLU_W-1:0]   plu_q;
	logic [LVL_W-1:0]   lvl_q;
	logic [QTY_W-1:0]   qin_q;
	logic [AMT_W-1:0]   ain_q;
	logic [IDX_W-1:0]   idx_q;
	logic [POS_W-1:0]   count_q;

	logic [CAPACITY-1:0] lt_q, eq_q, sel_q, after_q;
	logic                hit_q, full_q, found_q;
	logic [POS_W-1:0]    pos_q;
	key_t                gkey_q;
	logic [QTY_W-1:0]    gqty_q, qsum_q;
	logic [AMT_W-1:0]    gamt_q, asum_q;

	logic [OUT_W-1:0] out_q;
	logic             out_vld_q;

	cell_ctl_t  ctl;
	key_t       ckey [CAPACITY];
	qty_row_t   cqty [CAPACITY];
	amt_row_t   camt [CAPACITY];
	cell_stat_t cstat [CAPACITY];
	logic [CAPACITY-1:0] cvalid;

	logic upd_go, lvl_ok, insert;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;
	assign upd_go   = (state_q == S_UPD) && (!out_vld_q || m_tready);
	assign lvl_ok   = lvl_q < LVL_W'(LEVELS);
	assign insert   = !cmd_q && !hit_q && !full_q;

	always_comb begin
		ctl.shift = upd_go && insert;
		ctl.load  = upd_go && insert;
		ctl.wr    = upd_go && !cmd_q && hit_q;
		ctl.level = lvl_q;
		ctl.key   = {dept_q, plu_q};
		ctl.qty   = qsum_q;
		ctl.amt   = asum_q;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign cvalid[i] = POS_W'(i) < count_q;
		if (i == 0) begin : g_head
			ska_cell u_cell (
				.clk(clk), .ctl(ctl), .valid(cvalid[i]), .sel(sel_q[i]), .after(after_q[i]),
				.left_key('0), .left_qty('0), .left_amt('0),
				.key(ckey[i]), .qty(cqty[i]), .amt(camt[i]), .stat(cstat[i])
			);
		end else begin : g_body
			ska_cell u_cell (
				.clk(clk), .ctl(ctl), .valid(cvalid[i]), .sel(sel_q[i]), .after(after_q[i]),
				.left_key(ckey[i-1]), .left_qty(cqty[i-1]), .left_amt(camt[i-1]),
				.key(ckey[i]), .qty(cqty[i]), .amt(camt[i]), .stat(cstat[i])
			);
		end
	end

	// Gather the selected cell's data by a one-hot OR across the chain.
	logic             g_any, g_hit;
	logic [POS_W-1:0] g_pos;
	key_t             g_key;
	logic [QTY_W-1:0] g_qty, g_qbase;
	logic [AMT_W-1:0] g_amt, g_abase;

	always_comb begin
		g_any = 1'b0;
		g_hit = 1'b0;
		g_pos = '0;
		g_key = '0;
		g_qty = '0;
		g_amt = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			g_any = g_any | sel_q[i];
			g_hit = g_hit | (sel_q[i] & eq_q[i]);
			g_pos = g_pos | (sel_q[i] ? POS_W'(i) : '0);
			g_key = g_key | (sel_q[i] ? ckey[i] : '0);
			g_qty = g_qty | cstat[i].qty;
			g_amt = g_amt | cstat[i].amt;
		end
		g_qbase = g_hit ? g_qty : '0;
		g_abase = g_hit ? g_amt : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// A new result word replaces one that is being taken in the same cycle.
			if (upd_go)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_tvalid) state_q <= S_CMP;
				S_CMP:  state_q <= S_SEL;
				S_SEL:  state_q <= S_GAT;
				S_GAT:  state_q <= S_UPD;
				S_UPD: begin
					if (upd_go) begin
						state_q <= S_IDLE;
						if (insert)
							count_q <= count_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic [POS_W-1:0] cnt_next;
	logic             r_found, r_tot;
	logic [1:0]       r_status;
	assign cnt_next = insert ? count_q + 1'b1 : count_q;

	always_comb begin
		if (cmd_q) begin
			r_found  = found_q;
			r_tot    = found_q && lvl_ok;
			r_status = found_q ? ST_OK : ST_OOR;
		end else begin
			r_found  = hit_q;
			r_tot    = !full_q && lvl_ok;
			r_status = full_q ? ST_FULL : ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q  <= s_tuser;
			dept_q <= s_tdata[15:0];
			plu_q  <= s_tdata[62:16];
			lvl_q  <= s_tdata[66:63];
			qin_q  <= s_tdata[98:67];
			ain_q  <= s_tdata[138:99];
			idx_q  <= s_tdata[148:139];
		end
		if (state_q == S_CMP) begin
			for (int i = 0; i < CAPACITY; i++) begin
				lt_q[i] <= cstat[i].lt;
				eq_q[i] <= cstat[i].eq;
			end
		end
		if (state_q == S_SEL) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (cmd_q) begin
					sel_q[i]   <= idx_q == IDX_W'(i);
					after_q[i] <= 1'b0;
				end else begin
					sel_q[i]   <= !lt_q[i] && ((i == 0) ? 1'b1 : lt_q[(i == 0) ? 0 : i-1]);
					after_q[i] <= (i == 0) ? 1'b0 : !lt_q[(i == 0) ? 0 : i-1];
				end
			end
		end
		if (state_q == S_GAT) begin
			hit_q   <= !cmd_q && g_hit;
			full_q  <= !cmd_q && !g_hit && (count_q == POS_W'(CAPACITY));
			found_q <= POS_W'(idx_q) < count_q;
			pos_q   <= cmd_q ? POS_W'(idx_q) : (g_any ? g_pos : count_q);
			gkey_q  <= g_key;
			gqty_q  <= g_qty;
			gamt_q  <= g_amt;
			qsum_q  <= sat_qty(g_qbase, qin_q);
			asum_q  <= sat_amt(g_abase, ain_q);
		end
		if (upd_go) begin
			out_q <= {cnt_next, r_status,
				r_tot ? (cmd_q ? gamt_q : asum_q) : {AMT_W{1'b0}},
				r_tot ? (cmd_q ? gqty_q : qsum_q) : {QTY_W{1'b0}},
				cmd_q ? (found_q ? gkey_q[PLU_W-1:0] : {PLU_W{1'b0}}) : plu_q,
				cmd_q ? (found_q ? gkey_q[KEY_W-1:PLU_W] : {DEPT_W{1'b0}}) : dept_q,
				pos_q, r_found};
		end
	end

endmodule
`default_nettype wire

@@ test/tb_sorted_key_accumulate_table.sv @@
// Testbench for the sorted key accumulate table: directed and random words checked against a predictor.
`default_nettype none
module tb_sorted_key_accumulate_table;
	import ska_pkg::*;

	typedef enum logic {OP_CONSOLIDATE = 1'b0, OP_READ = 1'b1} op_e;

	// One result word, in the order of m_tdata from the lowest bit up.
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic [DEPT_W-1:0] dept;
		logic [PLU_W-1:0] plu;
		logic [QTY_W-1:0] qty_total;
		logic [AMT_W-1:0] amt_total;
		logic [1:0]       status;
		logic [POS_W-1:0] entry_count;
	} tally_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	sorted_key_accumulate_table uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the table, kept sorted exactly as the block keeps it.
	key_t             shadow_key [CAPACITY];
	logic [QTY_W-1:0] shadow_qty [CAPACITY][LEVELS];
	logic [AMT_W-1:0] shadow_amt [CAPACITY][LEVELS];
	int               shadow_count;

	tally_t pending_tallies[$];
	int     errors = 0;
	int     send_idle_pct = 0;
	int     recv_idle_pct = 0;
	int     hold_off = 0;

	// Keys already in the table, used to aim consolidates at existing entries.
	key_t known_keys[$];

	function automatic logic [QTY_W-1:0] clamp_qty(logic [QTY_W-1:0] a, logic [QTY_W-1:0] b);
		longint s;
		s = longint'($signed(a)) + longint'($signed(b));
		if (s > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (s < -64'sd2147483648) return 32'h8000_0000;
		return s[QTY_W-1:0];
	endfunction

	function automatic logic [AMT_W-1:0] clamp_amt(logic [AMT_W-1:0] a, logic [AMT_W-1:0] b);
		longint s;
		s = longint'($signed(a)) + longint'($signed(b));
		if (s > 64'sd549755813887) return 40'h7F_FFFF_FFFF;
		if (s < -64'sd549755813888) return 40'h80_0000_0000;
		return s[AMT_W-1:0];
	endfunction

	// Works out the result of one word and updates the shadow table.
	function automatic tally_t predict_tally(op_e op, logic [DEPT_W-1:0] dept,
		logic [PLU_W-1:0] plu, logic [LVL_W-1:0] lvl, logic [QTY_W-1:0] q,
		logic [AMT_W-1:0] a, logic [IDX_W-1:0] idx);
		tally_t t;
		key_t k;
		int lo, hi, mid;
		logic hit;
		t = '{default: '0};
		if (op == OP_CONSOLIDATE) begin
			k = {dept, plu};
			lo = 0;
			hi = shadow_count;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (shadow_key[mid] < k) lo = mid + 1;
				else hi = mid;
			end
			hit = (lo < shadow_count) && (shadow_key[lo] == k);
			t.position = lo[POS_W-1:0];
			t.dept = dept;
			t.plu = plu;
			if (hit) begin
				t.found = 1'b1;
			end else if (shadow_count >= CAPACITY) begin
				t.status = ST_FULL;
			end else begin
				for (int i = shadow_count; i > lo; i--) begin
					shadow_key[i] = shadow_key[i-1];
					shadow_qty[i] = shadow_qty[i-1];
					shadow_amt[i] = shadow_amt[i-1];
				end
				shadow_key[lo] = k;
				for (int l = 0; l < LEVELS; l++) begin
					shadow_qty[lo][l] = '0;
					shadow_amt[lo][l] = '0;
				end
				shadow_count++;
				known_keys.push_back(k);
				hit = 1'b1;
			end
			if (hit && lvl < LEVELS) begin
				shadow_qty[lo][lvl] = clamp_qty(shadow_qty[lo][lvl], q);
				shadow_amt[lo][lvl] = clamp_amt(shadow_amt[lo][lvl], a);
				t.qty_total = shadow_qty[lo][lvl];
				t.amt_total = shadow_amt[lo][lvl];
			end
		end else begin
			t.position = {1'b0, idx};
			if (idx < shadow_count) begin
				t.found = 1'b1;
				t.dept = shadow_key[idx][KEY_W-1:PLU_W];
				t.plu = shadow_key[idx][PLU_W-1:0];
				if (lvl < LEVELS) begin
					t.qty_total = shadow_qty[idx][lvl];
					t.amt_total = shadow_amt[idx][lvl];
				end
			end else begin
				t.status = ST_OOR;
			end
		end
		t.entry_count = shadow_count[POS_W-1:0];
		return t;
	endfunction

	// Offers one word at the falling edge and waits until it is taken. Valid stays up on
	// return; the next word replaces it, or wait_drained drops it.
	task automatic send_word(op_e op, logic [DEPT_W-1:0] dept, logic [PLU_W-1:0] plu,
		logic [LVL_W-1:0] lvl, logic [QTY_W-1:0] q, logic [AMT_W-1:0] a,
		logic [IDX_W-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(IN_W-149){1'b0}}, idx, a, q, lvl, plu, dept};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_tallies.push_back(predict_tally(op, dept, plu, lvl, q, a, idx));
		@(negedge clk);
	endtask

	// Receiver side: random stalls plus an optional long hold-off.
	always @(negedge clk) begin
		if (hold_off > 0) begin
			m_tready <= 1'b0;
			hold_off <= hold_off - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Checks every result word against the oldest expectation.
	always @(posedge clk) begin
		tally_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got.found = m_tdata[0];
			got.position = m_tdata[11:1];
			got.dept = m_tdata[27:12];
			got.plu = m_tdata[74:28];
			got.qty_total = m_tdata[106:75];
			got.amt_total = m_tdata[146:107];
			got.status = m_tdata[148:147];
			got.entry_count = m_tdata[159:149];
			if (pending_tallies.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, m_tdata);
				errors++;
			end else begin
				want = pending_tallies.pop_front();
				if (got != want) begin
					$display("%0t: mismatch expected %p actual %p", $time, want, got);
					errors++;
				end
			end
		end
	end

	function automatic logic [PLU_W-1:0] rand_plu();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[PLU_W-1:0];
	endfunction

	function automatic logic [QTY_W-1:0] rand_qty();
		case ($urandom_range(3))
			0: return 32'h7FFF_FFFF - $urandom_range(3);
			1: return 32'h8000_0000 + $urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [AMT_W-1:0] rand_amt();
		case ($urandom_range(3))
			0: return 40'h7F_FFFF_FFFF - $urandom_range(3);
			1: return 40'h80_0000_0000 + $urandom_range(3);
			default: return AMT_W'({$urandom, $urandom});
		endcase
	endfunction

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_tallies.size() != 0) @(negedge clk);
	endtask

	// Extremes of every field, both operations, bad levels and reads past the end.
	task automatic test_directed();
		send_word(OP_READ, 0, 0, 0, 0, 0, 0);
		send_word(OP_CONSOLIDATE, 16'hFFFF, {PLU_W{1'b1}}, 9, 32'h7FFF_FFFF,
			40'h7F_FFFF_FFFF, '1);
		send_word(OP_CONSOLIDATE, 16'hFFFF, {PLU_W{1'b1}}, 9, 1, 1, 0);
		send_word(OP_CONSOLIDATE, 0, 0, 0, 32'h8000_0000, 40'h80_0000_0000, 0);
		send_word(OP_CONSOLIDATE, 0, 0, 0, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 0);
		send_word(OP_CONSOLIDATE, 0, 1, 15, 5, 5, 0);
		send_word(OP_CONSOLIDATE, 1, 0, 10, 5, 5, 0);
		send_word(OP_CONSOLIDATE, 16'h8000, 47'h4000_0000_0000, 4, 1000, 100, 0);
		send_word(OP_CONSOLIDATE, 16'h8000, 47'h4000_0000_0000, 4, -1000, -100, 0);
		for (int i = 0; i < 6; i++)
			send_word(OP_READ, 0, 0, LVL_W'(i * 3), 0, 0, i[9:0]);
		send_word(OP_READ, 0, 0, 15, 0, 0, 1);
		send_word(OP_READ, 0, 0, 0, 0, 0, 10'h3FF);
		send_word(OP_READ, '1, '1, '1, '1, '1, 5);
		wait_drained();
	endtask

	// Mostly consolidates on a mix of new and known keys, with reads of held entries and past the end.
	task automatic test_random(int n);
		logic [DEPT_W-1:0] d;
		logic [PLU_W-1:0] p;
		key_t k;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					send_word(OP_READ, DEPT_W'($urandom), rand_plu(),
						LVL_W'($urandom_range(15)), $urandom, AMT_W'({$urandom, $urandom}),
						IDX_W'($urandom_range(9) == 0 ? $urandom : $urandom_range(shadow_count)));
				end
				3, 4, 5, 6: begin
					if (known_keys.size() != 0) begin
						k = known_keys[$urandom_range(known_keys.size() - 1)];
						d = k[KEY_W-1:PLU_W];
						p = k[PLU_W-1:0];
					end else begin
						d = DEPT_W'($urandom);
						p = rand_plu();
					end
					send_word(OP_CONSOLIDATE, d, p, LVL_W'($urandom_range(15)), rand_qty(),
						rand_amt(), IDX_W'($urandom));
				end
				default: begin
					d = DEPT_W'(($urandom_range(1) == 0) ? $urandom_range(3) : $urandom);
					p = ($urandom_range(1) == 0) ? PLU_W'($urandom_range(7)) : rand_plu();
					send_word(OP_CONSOLIDATE, d, p, LVL_W'($urandom_range(11)), rand_qty(),
						rand_amt(), IDX_W'($urandom));
				end
			endcase
		end
		wait_drained();
	endtask

	// Receiver stalls for a long stretch while words keep being offered.
	task automatic test_backpressure();
		hold_off = 300;
		send_idle_pct = 0;
		for (int i = 0; i < 20; i++)
			send_word(OP_CONSOLIDATE, DEPT_W'($urandom_range(3)), PLU_W'($urandom_range(3)),
				LVL_W'($urandom_range(9)), QTY_W'($urandom_range(100)),
				AMT_W'($urandom_range(100)), 0);
		wait_drained();
	endtask

	// Fills the table to capacity, then checks dropped inserts, the first and last entries and random reads.
	task automatic test_full_table();
		int d;
		d = 0;
		while (shadow_count < CAPACITY) begin
			send_word(OP_CONSOLIDATE, 16'h4000 + d[15:0], PLU_W'($urandom_range(1)),
				LVL_W'($urandom_range(9)), $urandom, AMT_W'({$urandom, $urandom}), 0);
			d++;
		end
		send_word(OP_CONSOLIDATE, 16'h3FFF, 0, 2, 7, 7, 0);
		send_word(OP_CONSOLIDATE, 16'hFFFF, {PLU_W{1'b1}}, 9, -1, -1, 0);
		send_word(OP_CONSOLIDATE, 16'h4000, 0, 1, 3, 3, 0);
		send_word(OP_READ, 0, 0, 9, 0, 0, 10'h3FF);
		send_word(OP_READ, 0, 0, 0, 0, 0, 10'h000);
		for (int i = 0; i < 60; i++)
			send_word(OP_READ, 0, 0, LVL_W'($urandom_range(15)), 0, 0, IDX_W'($urandom));
		wait_drained();
	endtask

	initial begin
		shadow_count = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		send_idle_pct = 35; recv_idle_pct = 46;
		test_random(350);
		send_idle_pct = 46; recv_idle_pct = 35;
		test_random(350);
		test_backpressure();
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(200);
		send_idle_pct = 10; recv_idle_pct = 10;
		test_full_table();
		repeat (20) @(negedge clk);
		if (errors == 0 && pending_tallies.size() == 0)
			$display("sorted_key_accumulate_table test passed");
		else
			$display("sorted_key_accumulate_table test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("sorted_key_accumulate_table test failed");
		$finish;
	end

endmodule
`default_nettype wire
